// ===== rtl/wspu_pkg.sv =====
package wspu_pkg;

  localparam int BlockFramesDef = 128;
  localparam int FmtMaxBytesDef = 40;

  localparam logic [31:0] IdRiff = 32'h46464952;
  localparam logic [31:0] IdWave = 32'h45564157;
  localparam logic [31:0] IdFmt  = 32'h20746D66;
  localparam logic [31:0] IdData = 32'h61746164;

  localparam logic [31:0] Rate44k = 32'd44100;
  localparam logic [31:0] Rate22k = 32'd22050;
  localparam logic [31:0] Rate11k = 32'd11025;

  localparam logic [1:0] CfgStart = 2'd0;
  localparam logic [1:0] CfgEnd   = 2'd1;
  localparam logic [1:0] CfgGain  = 2'd2;

  localparam logic [2:0] StParse  = 3'd0;
  localparam logic [2:0] StPlay   = 3'd1;
  localparam logic [2:0] StDone   = 3'd2;
  localparam logic [2:0] StBadHdr = 3'd3;
  localparam logic [2:0] StUnsup  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic              sample_valid;
    logic signed [15:0] sample;
    logic [1:0]        channel;
    logic              block_last;
    logic              stream_last;
    logic [2:0]        status;
  } out_item_t;

  // front-to-back command: raw sample word plus its marks
  typedef struct packed {
    logic        valid;
    logic [15:0] raw;
    logic [1:0]  channel;
    logic        block_last;
    logic        stream_last;
    logic [2:0]  status;
  } cmd_t;

endpackage

// ===== rtl/wspu_parser.sv =====
module wspu_parser #(
  parameter int BLOCK_FRAMES  = wspu_pkg::BlockFramesDef,
  parameter int FMT_MAX_BYTES = wspu_pkg::FmtMaxBytesDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  wspu_pkg::in_item_t item,
  input  logic [31:0]       start_offset,
  input  logic [31:0]       end_offset,
  output wspu_pkg::cmd_t    cmd,
  output logic              setup
);

  localparam int FbW = $clog2(BLOCK_FRAMES + 1);

  localparam logic [3:0] PhStopped = 4'd0;
  localparam logic [3:0] PhId      = 4'd1;
  localparam logic [3:0] PhFmt     = 4'd2;
  localparam logic [3:0] PhChunk   = 4'd3;
  localparam logic [3:0] PhSkipCh  = 4'd4;
  localparam logic [3:0] PhSkipPre = 4'd5;
  localparam logic [3:0] PhSeek    = 4'd6;
  localparam logic [3:0] PhPlay    = 4'd7;
  localparam logic [3:0] PhDone    = 4'd8;
  localparam logic [3:0] PhBadHdr  = 4'd9;
  localparam logic [3:0] PhUnsup   = 4'd10;

  logic [3:0]  parse_phase, parse_phase_next;
  logic [2:0]  play_mode, play_mode_next;
  logic [31:0] header_words [16];
  logic [5:0]  header_byte_count, header_byte_count_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] file_position, file_position_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [1:0]  byte_phase, byte_phase_next;
  logic [FbW-1:0] frame_in_block, frame_in_block_next;

  // start setup works on registered data-chunk context in the following cycle
  logic        setup_pend, setup_pend_next;
  logic [31:0] data_len, data_len_next;

  logic        wr_en;
  logic [3:0]  wr_idx;
  logic [1:0]  wr_lane;
  logic [31:0] w0, w1, w2, w3, w4;
  logic [31:0] w0n, w1n, w3n, w4n;

  wspu_pkg::cmd_t cmd_q, cmd_next;

  assign w0 = header_words[0];
  assign w1 = header_words[1];
  assign w2 = header_words[2];
  assign w3 = header_words[3];
  assign w4 = header_words[4];

  // header words as they stand after the current byte
  function automatic logic [31:0] merged(input logic [31:0] w, input logic [3:0] idx,
                                         input logic en, input logic [3:0] widx,
                                         input logic [1:0] lane, input logic [7:0] b);
    logic [31:0] r;
    r = w;
    if (en && idx == widx) r[lane*8 +: 8] = b;
    return r;
  endfunction

  always_comb begin
    wr_idx  = header_byte_count[5:2];
    wr_lane = header_byte_count[1:0];
    wr_en   = 1'b0;
    if (take && !item.new_file &&
        (parse_phase == PhId || parse_phase == PhFmt || parse_phase == PhChunk))
      wr_en = 1'b1;
    if (take && item.new_file) begin
      wr_en = 1'b1;
      wr_idx = 4'd0;
      wr_lane = 2'd0;
    end
    w0n = merged(w0, 4'd0, wr_en, wr_idx, wr_lane, item.data_byte);
    w1n = merged(w1, 4'd1, wr_en, wr_idx, wr_lane, item.data_byte);
    w3n = merged(w3, 4'd3, wr_en, wr_idx, wr_lane, item.data_byte);
    w4n = merged(w4, 4'd4, wr_en, wr_idx, wr_lane, item.data_byte);
  end

  always_ff @(posedge clk) begin
    if (wr_en) header_words[wr_idx][wr_lane*8 +: 8] <= item.data_byte;
  end

  always_comb begin
    logic [3:0]  ph;
    logic [31:0] br, brm;
    logic        hb_ok, fmt_ok;
    logic [2:0]  m;
    logic [15:0] bits, ch;
    logic [1:0]  last_ph;
    logic        slast;
    logic [2:0]  st;
    parse_phase_next       = parse_phase;
    play_mode_next         = play_mode;
    header_byte_count_next = header_byte_count;
    bytes_remaining_next   = bytes_remaining;
    file_position_next     = file_position;
    skip_remaining_next    = skip_remaining;
    low_byte_hold_next     = low_byte_hold;
    byte_phase_next        = byte_phase;
    frame_in_block_next    = frame_in_block;
    setup_pend_next        = 1'b0;
    data_len_next          = data_len;
    cmd_next               = '0;
    hb_ok = 1'b0; fmt_ok = 1'b0; m = '0; bits = '0; ch = '0;
    last_ph = '0; slast = 1'b0; st = wspu_pkg::StParse;
    ph = parse_phase;
    br = bytes_remaining;
    if (item.new_file) begin
      ph = PhId; br = 32'd20;
      header_byte_count_next = '0;
      file_position_next = '0;
      play_mode_next = '0;
      skip_remaining_next = '0;
      low_byte_hold_next = '0;
      byte_phase_next = '0;
      frame_in_block_next = '0;
    end
    brm = br - 32'd1;
    parse_phase_next = ph;
    bytes_remaining_next = br;
    if (ph != PhStopped) file_position_next = (item.new_file ? 32'd0 : file_position) + 32'd1;
    hb_ok = (item.new_file ? 6'd0 : header_byte_count) != 6'd63 || !wr_en;
    if (ph == PhId || ph == PhFmt || ph == PhChunk)
      header_byte_count_next = (item.new_file ? 6'd0 : header_byte_count) + 6'd1;
    unique case (ph)
      PhId: begin
        bytes_remaining_next = brm;
        if (brm == 32'd0) begin
          if (w0n != wspu_pkg::IdRiff || w2 != wspu_pkg::IdWave) begin
            parse_phase_next = PhBadHdr;
          end else if (w3n == wspu_pkg::IdFmt) begin
            if (w4n < 32'd16 || w4n > 32'(FMT_MAX_BYTES)) begin
              parse_phase_next = PhBadHdr;
            end else begin
              parse_phase_next = PhFmt;
              bytes_remaining_next = w4n;
              header_byte_count_next = '0;
            end
          end else begin
            header_byte_count_next = 6'd12;
            bytes_remaining_next = w4n;
            parse_phase_next = PhSkipPre;
            if (w4n == 32'd0) begin
              parse_phase_next = PhId;
              bytes_remaining_next = 32'd8;
            end
          end
        end
      end
      PhSkipPre: begin
        bytes_remaining_next = brm;
        if (brm == 32'd0) begin
          parse_phase_next = PhId;
          bytes_remaining_next = 32'd8;
        end
      end
      PhFmt: begin
        bytes_remaining_next = brm;
        if (brm == 32'd0) begin
          ch = w0n[31:16];
          bits = w3n[31:16];
          fmt_ok = w0n[15:0] == 16'd1;
          if (w1n == wspu_pkg::Rate22k || w1n == wspu_pkg::Rate11k) m[2] = 1'b1;
          else if (w1n != wspu_pkg::Rate44k) fmt_ok = 1'b0;
          if (ch == 16'd2) m[0] = 1'b1;
          else if (ch != 16'd1) fmt_ok = 1'b0;
          if (bits == 16'd16) m[1] = 1'b1;
          else if (bits != 16'd8) fmt_ok = 1'b0;
          if (fmt_ok) begin
            play_mode_next = m;
            parse_phase_next = PhChunk;
            bytes_remaining_next = 32'd8;
            header_byte_count_next = '0;
          end else begin
            parse_phase_next = PhUnsup;
          end
        end
      end
      PhChunk: begin
        bytes_remaining_next = brm;
        if (brm == 32'd0) begin
          if (w0n == wspu_pkg::IdData) begin
            // hold in a one-cycle setup state; the next byte waits on it
            setup_pend_next = 1'b1;
            data_len_next = w1n;
            parse_phase_next = PhDone;
          end else begin
            parse_phase_next = PhSkipCh;
            bytes_remaining_next = w1n;
            if (w1n == 32'd0) begin
              parse_phase_next = PhChunk;
              bytes_remaining_next = 32'd8;
              header_byte_count_next = '0;
            end
          end
        end
      end
      PhSkipCh: begin
        bytes_remaining_next = brm;
        if (brm == 32'd0) begin
          parse_phase_next = PhChunk;
          bytes_remaining_next = 32'd8;
          header_byte_count_next = '0;
        end
      end
      PhSeek: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (skip_remaining == 32'd1) parse_phase_next = PhPlay;
      end
      PhPlay: begin
        bytes_remaining_next = brm;
        if (play_mode == 3'd2 || play_mode == 3'd3) begin
          last_ph = (play_mode == 3'd2) ? 2'd1 : 2'd3;
          if (!byte_phase[0]) begin
            low_byte_hold_next = item.data_byte;
          end else begin
            cmd_next.raw = {item.data_byte, low_byte_hold};
            if (byte_phase == last_ph) begin
              cmd_next.valid = 1'b1;
              cmd_next.channel = (play_mode == 3'd2) ? 2'd0 : 2'd2;
              slast = brm < ((play_mode == 3'd2) ? 32'd2 : 32'd4);
              cmd_next.stream_last = slast;
              if (frame_in_block + FbW'(1) >= FbW'(BLOCK_FRAMES) || slast) begin
                cmd_next.block_last = 1'b1;
                frame_in_block_next = '0;
              end else begin
                frame_in_block_next = frame_in_block + FbW'(1);
              end
            end else if (brm >= 32'd2) begin
              cmd_next.valid = 1'b1;
              cmd_next.channel = 2'd1;
            end
          end
          byte_phase_next = (byte_phase == last_ph) ? 2'd0 : byte_phase + 2'd1;
        end
        if (brm == 32'd0) parse_phase_next = PhDone;
      end
      default: ;
    endcase
    if (!hb_ok) header_byte_count_next = header_byte_count;
    if (parse_phase_next >= PhId && parse_phase_next <= PhSkipPre) st = wspu_pkg::StParse;
    else if (parse_phase_next == PhSeek || parse_phase_next == PhPlay) st = wspu_pkg::StPlay;
    else if (parse_phase_next == PhBadHdr) st = wspu_pkg::StBadHdr;
    else if (parse_phase_next == PhUnsup) st = wspu_pkg::StUnsup;
    else st = wspu_pkg::StDone;
    cmd_next.status = st;
  end

  // data start: offset arithmetic on registered context
  logic [32:0] seek;
  logic [31:0] actual, len_s;
  always_comb begin
    seek = {1'b0, file_position} + {1'b0, start_offset};
    if (play_mode == 3'd3) seek[1:0] = 2'b00;
    else if (play_mode == 3'd2) seek[0] = 1'b0;
    actual = '0;
    len_s = data_len;
    if (start_offset != 32'd0) begin
      if (seek > {1'b0, file_position}) actual = 32'(seek - {1'b0, file_position});
      len_s = (actual >= data_len) ? 32'd0 : data_len - actual;
    end
    if (end_offset != 32'd0 && end_offset < len_s)
      len_s = (end_offset > start_offset) ? end_offset - start_offset : 32'd0;
  end

  // the data header's transaction leaves during the setup cycle with its final status
  always_comb begin
    cmd = cmd_q;
    if (setup_pend) cmd.status = (len_s == 32'd0) ? wspu_pkg::StDone : wspu_pkg::StPlay;
  end

  assign setup = setup_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PhStopped;
      play_mode <= '0;
      header_byte_count <= '0;
      bytes_remaining <= '0;
      file_position <= '0;
      skip_remaining <= '0;
      low_byte_hold <= '0;
      byte_phase <= '0;
      frame_in_block <= '0;
      setup_pend <= 1'b0;
      cmd_q <= '0;
    end else if (setup_pend) begin
      setup_pend <= 1'b0;
      bytes_remaining <= len_s;
      skip_remaining <= actual;
      byte_phase <= '0;
      frame_in_block <= '0;
      low_byte_hold <= '0;
      if (len_s == 32'd0) parse_phase <= PhDone;
      else if (actual != 32'd0) parse_phase <= PhSeek;
      else parse_phase <= PhPlay;
    end else if (take) begin
      parse_phase <= parse_phase_next;
      play_mode <= play_mode_next;
      header_byte_count <= header_byte_count_next;
      bytes_remaining <= bytes_remaining_next;
      file_position <= file_position_next;
      skip_remaining <= skip_remaining_next;
      low_byte_hold <= low_byte_hold_next;
      byte_phase <= byte_phase_next;
      frame_in_block <= frame_in_block_next;
      setup_pend <= setup_pend_next;
      cmd_q <= cmd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) data_len <= data_len_next;
  end

endmodule

// ===== rtl/wav_stream_pcm_unpacker.sv =====
// A byte's result is on the output once it has passed the gain multiply
// register and then the queue write, after the edge that takes it.
// Throughput: one byte per cycle, except in the setup state after the data
// chunk header, in which the start offset is resolved and push is held off,
// and except while the queue and the two stages in flight would overfill it.
// Reset (rst, synchronous) stops the parser (status finished), empties the
// queue and sets start 0, end 0 and gain 1.0.
module wav_stream_pcm_unpacker #(
  parameter int BLOCK_FRAMES  = wspu_pkg::BlockFramesDef,
  parameter int FMT_MAX_BYTES = wspu_pkg::FmtMaxBytesDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  wspu_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output wspu_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  logic [31:0] start_offset, end_offset;
  logic [14:0] volume_gain;
  logic        take, busy;
  logic        c_v, m_v;
  logic        setup;
  wspu_pkg::cmd_t cmd;
  wspu_pkg::out_item_t m_item;
  wspu_pkg::out_item_t q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic signed [31:0] prod;
  logic [31:0] mag;
  logic signed [16:0] q17;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
      end_offset <= '0;
      volume_gain <= 15'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wspu_pkg::CfgStart: start_offset <= cfg_data;
        wspu_pkg::CfgEnd:   end_offset <= cfg_data;
        wspu_pkg::CfgGain:  volume_gain <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // two results in flight above the queue: keep space for them
  assign busy = setup;
  assign full = busy || (cnt + {2'b0, c_v} + {2'b0, m_v} > 3'd3);
  assign take = push && !full;

  wspu_parser #(.BLOCK_FRAMES(BLOCK_FRAMES), .FMT_MAX_BYTES(FMT_MAX_BYTES)) u_parser (
    .clk, .rst, .take, .item(in_item), .start_offset, .end_offset, .cmd, .setup
  );

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else c_v <= take;
  end

  always_comb begin
    prod = $signed(cmd.raw) * $signed({1'b0, volume_gain});
    mag = prod[31] ? 32'(-prod) : 32'(prod);
    mag = mag >> 12;
    q17 = prod[31] ? -$signed({1'b0, mag[15:0]}) : $signed({1'b0, mag[15:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else m_v <= c_v;
    m_item.sample_valid <= cmd.valid;
    m_item.channel <= cmd.channel;
    m_item.block_last <= cmd.block_last;
    m_item.stream_last <= cmd.stream_last;
    m_item.status <= cmd.status;
    if (!cmd.valid) m_item.sample <= '0;
    else if (!prod[31] && mag > 32'd32767) m_item.sample <= 16'sd32767;
    else if (prod[31] && mag > 32'd32768) m_item.sample <= -16'sd32768;
    else m_item.sample <= q17[15:0];
  end

  always_ff @(posedge clk) begin
    if (m_v) q[wp] <= m_item;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (m_v) wp <= wp + 2'd1;
      if (pop && !empty) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, m_v} - {2'b0, pop && !empty};
    end
  end

  assign empty = cnt == 3'd0;
  assign out_item = q[rp];

  assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) m_v |-> cnt < 3'd4)
    else $error("result written into full queue");
  assert property (@(posedge clk) disable iff (rst) take |=> c_v)
    else $error("accepted byte lost");

endmodule
